// ----- rtl/yuvrgb_pkg.sv -----
// Shared constants, register codes and pipeline control types for the YUV to RGB converter.
package yuvrgb_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int REG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int SAMPLE_W       = 8;
  localparam int LUMA_OFS_W     = 9;
  localparam int OPERAND_W      = 10;
  localparam int FRAC_BITS      = 13;
  localparam int ROUND_CONST    = 4096;
  localparam int CHROMA_BIAS    = 128;
  localparam int NUM_STAGES     = 4;

  localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUE_COEFFS  = 3'd0,
    REG_GREEN_COEFFS = 3'd1,
    REG_RED_COEFFS   = 3'd2,
    REG_LUMA_OFFSET  = 3'd3,
    REG_ALPHA_SOURCE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

// ----- rtl/yuvrgb_cfg.sv -----
// Configuration register file: coefficient rows, luma offset and alpha mode.
module yuvrgb_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [yuvrgb_pkg::REG_W-1:0]          cfg_data_i,
  output logic [yuvrgb_pkg::REG_W-1:0]          blue_coeffs_o,
  output logic [yuvrgb_pkg::REG_W-1:0]          green_coeffs_o,
  output logic [yuvrgb_pkg::REG_W-1:0]          red_coeffs_o,
  output logic [yuvrgb_pkg::LUMA_OFS_W-1:0]     luma_offset_o,
  output logic                                  alpha_source_o
);

  logic [yuvrgb_pkg::REG_W-1:0]      blue_q, green_q, red_q;
  logic [yuvrgb_pkg::LUMA_OFS_W-1:0] luma_ofs_q;
  logic                              alpha_src_q;
  logic                              wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blue_q      <= '0;
      green_q     <= '0;
      red_q       <= '0;
      luma_ofs_q  <= '0;
      alpha_src_q <= 1'b0;
    end else if (wr_en) begin
      case (yuvrgb_pkg::cfg_idx_e'(cfg_index_i))
        yuvrgb_pkg::REG_BLUE_COEFFS:  blue_q      <= cfg_data_i;
        yuvrgb_pkg::REG_GREEN_COEFFS: green_q     <= cfg_data_i;
        yuvrgb_pkg::REG_RED_COEFFS:   red_q       <= cfg_data_i;
        yuvrgb_pkg::REG_LUMA_OFFSET:  luma_ofs_q  <= cfg_data_i[yuvrgb_pkg::LUMA_OFS_W-1:0];
        yuvrgb_pkg::REG_ALPHA_SOURCE: alpha_src_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign blue_coeffs_o  = blue_q;
  assign green_coeffs_o = green_q;
  assign red_coeffs_o   = red_q;
  assign luma_offset_o  = luma_ofs_q;
  assign alpha_source_o = alpha_src_q;

endmodule

// ----- rtl/yuvrgb_ctrl.sv -----
// Valid bits and per-stage advance enables of the four-stage pipeline.
module yuvrgb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output yuvrgb_pkg::pipe_ctrl_t ctrl_o
);

  localparam int N = yuvrgb_pkg::NUM_STAGES;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] adv;
  logic [N-1:0] feed;

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    adv[N-1] = ~vld_q[N-1] | ~out_stall_i;
    for (int k = N-2; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
  end

  assign feed = {vld_q[N-2:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < N; k++) begin
      vld_d[k] = adv[k] ? feed[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = vld_q[N-1];
  assign ctrl_o.adv  = adv;
  assign ctrl_o.vld  = vld_q;

endmodule

// ----- rtl/yuvrgb_front.sv -----
// First stage: luma offset, chroma bias removal and alpha selection.
module yuvrgb_front (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]           luma_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]           chroma_blue_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]           chroma_red_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]           alpha_in_i,
  input  logic [yuvrgb_pkg::LUMA_OFS_W-1:0]         luma_offset_i,
  input  logic                                      alpha_source_i,
  output logic signed [yuvrgb_pkg::OPERAND_W-1:0]   y_o,
  output logic signed [yuvrgb_pkg::OPERAND_W-1:0]   u_o,
  output logic signed [yuvrgb_pkg::OPERAND_W-1:0]   v_o,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]           alpha_o
);

  localparam int OW = yuvrgb_pkg::OPERAND_W;
  localparam int SW = yuvrgb_pkg::SAMPLE_W;
  localparam logic signed [OW-1:0] BIAS = OW'(yuvrgb_pkg::CHROMA_BIAS);

  logic signed [OW-1:0] y_d, u_d, v_d, y_q, u_q, v_q;
  logic [SW-1:0]        alpha_d, alpha_q;

  always_comb begin
    y_d = signed'({{(OW-SW){1'b0}}, luma_i})
        + signed'({{(OW-yuvrgb_pkg::LUMA_OFS_W){luma_offset_i[yuvrgb_pkg::LUMA_OFS_W-1]}},
                   luma_offset_i});
    u_d = signed'({{(OW-SW){1'b0}}, chroma_blue_i}) - BIAS;
    v_d = signed'({{(OW-SW){1'b0}}, chroma_red_i}) - BIAS;
    alpha_d = alpha_source_i ? alpha_in_i : yuvrgb_pkg::ALPHA_OPAQUE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q     <= y_d;
      u_q     <= u_d;
      v_q     <= v_d;
      alpha_q <= alpha_d;
    end
  end

  assign y_o     = y_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign alpha_o = alpha_q;

endmodule

// ----- rtl/yuvrgb_chan.sv -----
// One color channel: products, sum with rounding, shift and clamp over three stages.
module yuvrgb_chan #(
  parameter int COEF_WIDTH = yuvrgb_pkg::COEF_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    prod_en_i,
  input  logic                                    sum_en_i,
  input  logic                                    out_en_i,
  input  logic [yuvrgb_pkg::REG_W-1:0]            coeffs_i,
  input  logic signed [yuvrgb_pkg::OPERAND_W-1:0] y_i,
  input  logic signed [yuvrgb_pkg::OPERAND_W-1:0] u_i,
  input  logic signed [yuvrgb_pkg::OPERAND_W-1:0] v_i,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]         chan_o
);

  localparam int CW = COEF_WIDTH;
  localparam int RW = yuvrgb_pkg::REG_W;
  localparam int PW = CW + yuvrgb_pkg::OPERAND_W;
  localparam int SW = PW + 2;
  localparam int FB = yuvrgb_pkg::FRAC_BITS;
  localparam int BW = yuvrgb_pkg::SAMPLE_W;

  logic [3*CW+RW-1:0]   coef_wide;
  logic [3*CW-1:0]      coef_row;
  logic signed [CW-1:0] cy, cu, cv;

  logic signed [PW-1:0] py_d, pu_d, pv_d, py_q, pu_q, pv_q;
  logic signed [SW-1:0] sum_d, sum_q;
  logic [BW-1:0]        chan_d, chan_q;

  // Row bits beyond the register width read as zero; register bits beyond the row width are ignored.
  assign coef_wide = {{(3*CW){1'b0}}, coeffs_i};
  assign coef_row  = coef_wide[3*CW-1:0];
  assign cy = signed'(coef_row[CW-1:0]);
  assign cu = signed'(coef_row[2*CW-1:CW]);
  assign cv = signed'(coef_row[3*CW-1:2*CW]);

  assign py_d = cy * y_i;
  assign pu_d = cu * u_i;
  assign pv_d = cv * v_i;

  assign sum_d = SW'(py_q) + SW'(pu_q) + SW'(pv_q) + SW'(yuvrgb_pkg::ROUND_CONST);

  always_comb begin
    if (sum_q[SW-1]) begin
      chan_d = '0;
    end else if (|sum_q[SW-1:FB+BW]) begin
      chan_d = '1;
    end else begin
      chan_d = sum_q[FB+BW-1:FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      py_q <= py_d;
      pu_q <= pu_d;
      pv_q <= pv_d;
    end
    if (sum_en_i) begin
      sum_q <= sum_d;
    end
    if (out_en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// ----- rtl/yuv444_to_rgb_matrix_convert_top.sv -----
// Top level of the YUV 4:4:4 to RGB matrix converter.
// Takes one pixel per clock unless in_stall_o is high and returns one BGRA word per
// pixel. Each word is taken from the outputs when out_valid_o is high and the output
// is not stalled. The four register stages are: operand
// preparation, the nine coefficient multipliers, the rounding adder, and the
// shift/clamp output register. Each stage holds its word until the next one frees,
// so bubbles close up under stall. Configuration writes are taken every cycle and
// are meant to happen while no pixel is in flight.
module yuv444_to_rgb_matrix_convert_top #(
  parameter int COEF_WIDTH = yuvrgb_pkg::COEF_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [yuvrgb_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]      luma_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]      chroma_blue_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]      chroma_red_i,
  input  logic [yuvrgb_pkg::SAMPLE_W-1:0]      alpha_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]      blue_o,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]      green_o,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]      red_o,
  output logic [yuvrgb_pkg::SAMPLE_W-1:0]      alpha_out_o
);

  localparam int OW = yuvrgb_pkg::OPERAND_W;
  localparam int BW = yuvrgb_pkg::SAMPLE_W;

  logic [yuvrgb_pkg::REG_W-1:0]      blue_coeffs, green_coeffs, red_coeffs;
  logic [yuvrgb_pkg::LUMA_OFS_W-1:0] luma_offset;
  logic                              alpha_source;
  yuvrgb_pkg::pipe_ctrl_t            ctrl;

  logic signed [OW-1:0] y_s1, u_s1, v_s1;
  logic [BW-1:0]        alpha_s1, alpha_s2_q, alpha_s3_q, alpha_s4_q;

  yuvrgb_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .blue_coeffs_o  (blue_coeffs),
    .green_coeffs_o (green_coeffs),
    .red_coeffs_o   (red_coeffs),
    .luma_offset_o  (luma_offset),
    .alpha_source_o (alpha_source)
  );

  yuvrgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  yuvrgb_front u_front (
    .clk_i          (clk_i),
    .en_i           (ctrl.adv[0]),
    .luma_i         (luma_i),
    .chroma_blue_i  (chroma_blue_i),
    .chroma_red_i   (chroma_red_i),
    .alpha_in_i     (alpha_in_i),
    .luma_offset_i  (luma_offset),
    .alpha_source_i (alpha_source),
    .y_o            (y_s1),
    .u_o            (u_s1),
    .v_o            (v_s1),
    .alpha_o        (alpha_s1)
  );

  yuvrgb_chan #(.COEF_WIDTH(COEF_WIDTH)) u_chan_blue (
    .clk_i     (clk_i),
    .prod_en_i (ctrl.adv[1]),
    .sum_en_i  (ctrl.adv[2]),
    .out_en_i  (ctrl.adv[3]),
    .coeffs_i  (blue_coeffs),
    .y_i       (y_s1),
    .u_i       (u_s1),
    .v_i       (v_s1),
    .chan_o    (blue_o)
  );

  yuvrgb_chan #(.COEF_WIDTH(COEF_WIDTH)) u_chan_green (
    .clk_i     (clk_i),
    .prod_en_i (ctrl.adv[1]),
    .sum_en_i  (ctrl.adv[2]),
    .out_en_i  (ctrl.adv[3]),
    .coeffs_i  (green_coeffs),
    .y_i       (y_s1),
    .u_i       (u_s1),
    .v_i       (v_s1),
    .chan_o    (green_o)
  );

  yuvrgb_chan #(.COEF_WIDTH(COEF_WIDTH)) u_chan_red (
    .clk_i     (clk_i),
    .prod_en_i (ctrl.adv[1]),
    .sum_en_i  (ctrl.adv[2]),
    .out_en_i  (ctrl.adv[3]),
    .coeffs_i  (red_coeffs),
    .y_i       (y_s1),
    .u_i       (u_s1),
    .v_i       (v_s1),
    .chan_o    (red_o)
  );

  // Carry alpha alongside the color datapath.
  always_ff @(posedge clk_i) begin
    if (ctrl.adv[1]) begin
      alpha_s2_q <= alpha_s1;
    end
    if (ctrl.adv[2]) begin
      alpha_s3_q <= alpha_s2_q;
    end
    if (ctrl.adv[3]) begin
      alpha_s4_q <= alpha_s3_q;
    end
  end

  assign alpha_out_o = alpha_s4_q;

endmodule

// ----- rtl/yuvrgb_checker.sv -----
// Port-level checker for the converter top level, bound to it.
module yuvrgb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [yuvrgb_pkg::SAMPLE_W-1:0] blue_o,
  input logic [yuvrgb_pkg::SAMPLE_W-1:0] green_o,
  input logic [yuvrgb_pkg::SAMPLE_W-1:0] red_o,
  input logic [yuvrgb_pkg::SAMPLE_W-1:0] alpha_out_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(blue_o) && $stable(green_o)
                                    && $stable(red_o) && $stable(alpha_out_o))
    else $error("output word changed under stall");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("pixel did not reach the output in four cycles");

endmodule

bind yuv444_to_rgb_matrix_convert_top yuvrgb_checker u_yuvrgb_checker (.*);

// ----- tb/sv/yuv_rgb_checker.sv -----
// Checker for the YUV to RGB converter: tracks register writes, predicts each BGRA word and compares.
module yuv_rgb_checker
  import yuvrgb_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [REG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [SAMPLE_W-1:0]   luma_i,
  input  logic [SAMPLE_W-1:0]   chroma_blue_i,
  input  logic [SAMPLE_W-1:0]   chroma_red_i,
  input  logic [SAMPLE_W-1:0]   alpha_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMPLE_W-1:0]   blue_i,
  input  logic [SAMPLE_W-1:0]   green_i,
  input  logic [SAMPLE_W-1:0]   red_i,
  input  logic [SAMPLE_W-1:0]   alpha_out_i,
  output int unsigned           pending_o,
  output int unsigned           err_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] alpha;
  } bgra_t;

  logic [REG_W-1:0]             blue_row;
  logic [REG_W-1:0]             green_row;
  logic [REG_W-1:0]             red_row;
  logic signed [LUMA_OFS_W-1:0] luma_ofs;
  logic                         alpha_pass;
  bgra_t                        bgra_due_q[$];
  int unsigned                  errs = 0;

  assign err_count_o = errs;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    errs++;
  endtask

  function automatic longint coef_slot(input logic [REG_W-1:0] row, input int slot);
    logic [63:0]           wide;
    logic [COEF_WIDTH-1:0] raw;
    wide = 64'(row);
    raw  = wide[slot*COEF_WIDTH +: COEF_WIDTH];
    return longint'($signed(raw));
  endfunction

  function automatic logic [SAMPLE_W-1:0] mix_channel(input logic [REG_W-1:0] row,
                                                      input longint y, input longint u,
                                                      input longint v);
    longint acc;
    acc = coef_slot(row, 0) * y + coef_slot(row, 1) * u + coef_slot(row, 2) * v
        + ROUND_CONST;
    if (acc < 0) return '0;
    acc = acc >>> FRAC_BITS;
    if (acc > 255) return '1;
    return SAMPLE_W'(acc);
  endfunction

  function automatic bgra_t predict_pixel(input logic [SAMPLE_W-1:0] l,
                                          input logic [SAMPLE_W-1:0] cb,
                                          input logic [SAMPLE_W-1:0] cr,
                                          input logic [SAMPLE_W-1:0] a);
    longint y;
    longint u;
    longint v;
    bgra_t  px;
    y = longint'(l) + longint'(luma_ofs);
    u = longint'(cb) - CHROMA_BIAS;
    v = longint'(cr) - CHROMA_BIAS;
    px.blue  = mix_channel(blue_row, y, u, v);
    px.green = mix_channel(green_row, y, u, v);
    px.red   = mix_channel(red_row, y, u, v);
    px.alpha = alpha_pass ? a : ALPHA_OPAQUE;
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bgra_t want;
    if (!rst_ni) begin
      blue_row   = '0;
      green_row  = '0;
      red_row    = '0;
      luma_ofs   = '0;
      alpha_pass = 1'b0;
      bgra_due_q.delete();
      pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_BLUE_COEFFS:  blue_row = cfg_data_i;
          REG_GREEN_COEFFS: green_row = cfg_data_i;
          REG_RED_COEFFS:   red_row = cfg_data_i;
          REG_LUMA_OFFSET:  luma_ofs = $signed(cfg_data_i[LUMA_OFS_W-1:0]);
          REG_ALPHA_SOURCE: alpha_pass = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        bgra_due_q.push_back(predict_pixel(luma_i, chroma_blue_i, chroma_red_i, alpha_in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (bgra_due_q.size() == 0) begin
          report($sformatf("unexpected word b=%0d g=%0d r=%0d a=%0d",
                           blue_i, green_i, red_i, alpha_out_i));
        end else begin
          want = bgra_due_q.pop_front();
          if (blue_i !== want.blue)
            report($sformatf("blue got %0d expected %0d", blue_i, want.blue));
          if (green_i !== want.green)
            report($sformatf("green got %0d expected %0d", green_i, want.green));
          if (red_i !== want.red)
            report($sformatf("red got %0d expected %0d", red_i, want.red));
          if (alpha_out_i !== want.alpha)
            report($sformatf("alpha got %0d expected %0d", alpha_out_i, want.alpha));
        end
      end
      pending_o <= bgra_due_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the YUV to RGB converter: clock, reset, register loads, pixel stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import yuvrgb_pkg::*;

  localparam int COEF_W     = COEF_WIDTH_DEF;
  localparam int QUIET_MAX  = 4000;
  localparam int SEG_PIXELS = 146;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [SAMPLE_W-1:0]  luma_i;
  logic [SAMPLE_W-1:0]  chroma_blue_i;
  logic [SAMPLE_W-1:0]  chroma_red_i;
  logic [SAMPLE_W-1:0]  alpha_in_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]  blue_o;
  logic [SAMPLE_W-1:0]  green_o;
  logic [SAMPLE_W-1:0]  red_o;
  logic [SAMPLE_W-1:0]  alpha_out_o;

  int unsigned pending;
  int unsigned err_count;
  int unsigned quiet_cycles = 0;
  int          send_idle_pct = 35;
  int          recv_stall_pct = 67;

  yuv444_to_rgb_matrix_convert_top #(.COEF_WIDTH(COEF_W)) DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .luma_i, .chroma_blue_i, .chroma_red_i, .alpha_in_i,
    .out_valid_o, .out_stall_i, .blue_o, .green_o, .red_o, .alpha_out_o
  );

  yuv_rgb_checker #(.COEF_WIDTH(COEF_W)) u_checker (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .in_valid_i,
    .in_stall_i    (in_stall_o),
    .luma_i, .chroma_blue_i, .chroma_red_i, .alpha_in_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .blue_i        (blue_o),
    .green_i       (green_o),
    .red_i         (red_o),
    .alpha_out_i   (alpha_out_o),
    .pending_o     (pending),
    .err_count_o   (err_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [REG_W-1:0] pack_weights(input int cy, input int cu, input int cv);
    logic [63:0] w;
    w = '0;
    w[0 +: COEF_W]        = COEF_W'(cy);
    w[COEF_W +: COEF_W]   = COEF_W'(cu);
    w[2*COEF_W +: COEF_W] = COEF_W'(cv);
    return w[REG_W-1:0];
  endfunction

  function automatic int random_weight(input int mode);
    case (mode)
      0: return $urandom_range(8191) - 4096;
      1: return $urandom_range(32767) - 16384;
      default: begin
        case ($urandom_range(3))
          0: return 32767;
          1: return -32768;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [REG_W-1:0] random_row();
    int mode;
    mode = $urandom_range(3);
    if (mode == 3) return REG_W'({$urandom, $urandom});
    return pack_weights(random_weight(mode), random_weight(mode), random_weight(mode));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [REG_W-1:0] b_row, input logic [REG_W-1:0] g_row,
                             input logic [REG_W-1:0] r_row, input int ofs,
                             input bit pass, input bit spare);
    logic [REG_W-1:0]     ofs_word;
    logic [REG_W-1:0]     mode_word;
    logic [CFG_IDX_W-1:0] spare_idx;
    ofs_word  = REG_W'({$urandom, $urandom});
    ofs_word[LUMA_OFS_W-1:0] = LUMA_OFS_W'(ofs);
    mode_word = REG_W'({$urandom, $urandom});
    mode_word[0] = pass;
    cfg_write(REG_BLUE_COEFFS, b_row);
    cfg_write(REG_GREEN_COEFFS, g_row);
    cfg_write(REG_RED_COEFFS, r_row);
    cfg_write(REG_LUMA_OFFSET, ofs_word);
    cfg_write(REG_ALPHA_SOURCE, mode_word);
    if (spare) begin
      for (spare_idx = CFG_IDX_W'(REG_ALPHA_SOURCE) + 1'b1; spare_idx != '0; spare_idx++)
        cfg_write(spare_idx, REG_W'({$urandom, $urandom}));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] cb,
                            input logic [SAMPLE_W-1:0] cr, input logic [SAMPLE_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    luma_i        <= l;
    chroma_blue_i <= cb;
    chroma_red_i  <= cr;
    alpha_in_i    <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [REG_W-1:0] bt_blue;
    logic [REG_W-1:0] bt_green;
    logic [REG_W-1:0] bt_red;
    int               phase;
    int               seg;
    bt_blue  = pack_weights(9535, 16531, 0);
    bt_green = pack_weights(9535, -3209, -6660);
    bt_red   = pack_weights(9535, 0, 13074);
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    luma_i        <= '0;
    chroma_blue_i <= '0;
    chroma_red_i  <= '0;
    alpha_in_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    drain();

    load_config(bt_blue, bt_green, bt_red, -16, 1'b1, 1'b1);
    send_pixel(8'd16, 8'd128, 8'd128, 8'h00);
    send_pixel(8'd235, 8'd128, 8'd128, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h01);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h7F);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFE);
    send_pixel(8'd81, 8'd90, 8'd240, 8'h33);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pixel(8'd128, 8'd128, 8'd128, 8'hCC);
    drain();

    load_config(pack_weights(32767, 32767, 32767), pack_weights(-32768, -32768, -32768),
                pack_weights(32767, -32768, 0), 255, 1'b0, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hAA);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h55);
    drain();

    load_config(bt_blue, bt_green, bt_red, -256, 1'b1, 1'b0);
    send_pixel(8'h00, 8'd128, 8'd128, 8'h07);
    send_pixel(8'hFF, 8'd128, 8'd128, 8'd200);
    send_pixel(8'hFF, 8'hFF, 8'h00, 8'h09);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 35;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        load_config(random_row(), random_row(), random_row(), $urandom_range(511) - 256,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (SEG_PIXELS)
          send_pixel(SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)),
                     SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)));
        drain();
      end
    end

    repeat (2 * NUM_STAGES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- yuv444_to_rgb_matrix_convert_top.f -----
rtl/yuvrgb_pkg.sv
rtl/yuvrgb_cfg.sv
rtl/yuvrgb_ctrl.sv
rtl/yuvrgb_front.sv
rtl/yuvrgb_chan.sv
rtl/yuv444_to_rgb_matrix_convert_top.sv
rtl/yuvrgb_checker.sv
tb/sv/yuv_rgb_checker.sv
tb/sv/tb.sv
